>>> rtl/plti_pkg.sv
`default_nettype none

package plti_pkg;

  localparam logic [31:0] ONE_Q24 = 32'd16777216;
  localparam logic [63:0] QMAG_LIMIT = 64'd1 << 40;

  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_EMPTY = 2'd1,
    K_UNIT  = 2'd2,
    K_EVAL  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  idx;
    logic [30:0] ktime;
    logic [31:0] data;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/plti_front.sv
`default_nettype none

module plti_front import plti_pkg::*; #(
  parameter int MAX_KNOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [5:0]  knot_index,
  input  wire logic [30:0] knot_time,
  input  wire logic [31:0] knot_value,
  input  wire logic [31:0] query_time,
  input  wire logic        n_zero,
  output logic             deq_valid,
  input  wire logic        deq_ready,
  output entry_t           deq_entry
);

  entry_t     slots [2];
  logic [1:0] cnt;
  logic       wp;
  logic       rp;
  entry_t     cls;
  logic       keep;
  logic       push;
  logic       pop;

  always_comb begin
    cls.idx   = knot_index;
    cls.ktime = knot_time;
    cls.data  = action ? query_time : knot_value;
    keep      = 1'b1;
    if (!action) begin
      cls.kind = K_LOAD;
      keep     = (32'(knot_index) < MAX_KNOTS);
    end else if (n_zero) begin
      cls.kind = K_EMPTY;
    end else if ($signed(query_time) <= 0) begin
      cls.kind = K_UNIT;
    end else begin
      cls.kind = K_EVAL;
    end
  end

  assign in_ready  = (cnt != 2'd2);
  assign deq_valid = (cnt != 2'd0);
  assign deq_entry = slots[rp];
  assign push      = in_valid && in_ready && keep;
  assign pop       = deq_valid && deq_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/plti_back.sv
`default_nettype none

module plti_back import plti_pkg::*; #(
  parameter int MAX_KNOTS = 64,
  parameter int AW = $clog2(MAX_KNOTS),
  parameter int NW = $clog2(MAX_KNOTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [NW-1:0] n,
  input  wire logic          deq_valid,
  output logic               deq_ready,
  input  wire entry_t        deq_entry,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        curve_value,
  output logic               status
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_WAIT = 13'b0000000000010,
    S_SCAN = 13'b0000000000100,
    S_CLS  = 13'b0000000001000,
    S_BS   = 13'b0000000010000,
    S_BSC  = 13'b0000000100000,
    S_G0   = 13'b0000001000000,
    S_G1   = 13'b0000010000000,
    S_MUL0 = 13'b0000100000000,
    S_MUL1 = 13'b0001000000000,
    S_DIV  = 13'b0010000000000,
    S_FIN  = 13'b0100000000000,
    S_EMIT = 13'b1000000000000
  } state_t;

  logic [30:0] times  [MAX_KNOTS];
  logic [31:0] values [MAX_KNOTS];

  state_t             state;
  state_t             after;
  logic [AW-1:0]      ra;
  logic [AW-1:0]      i;
  logic [NW-1:0]      lo;
  logic [NW-1:0]      hi;
  logic [30:0]        rt;
  logic [31:0]        rv;
  logic [31:0]        tq;
  logic [30:0]        tf;
  logic [31:0]        yf;
  logic [30:0]        tl;
  logic [31:0]        yl;
  logic [31:0]        base;
  logic signed [32:0] a;
  logic signed [32:0] b;
  logic signed [32:0] d;
  logic [63:0]        prod;
  logic [34:0]        rem;
  logic [5:0]         cnt;
  logic [31:0]        res_value;
  logic               res_status;

  logic               mem_we;
  logic [AW-1:0]      wa;
  logic [32:0]        ma;
  logic [31:0]        mb;
  logic [32:0]        md;
  logic               neg;
  logic [NW-1:0]      nm1;
  logic [NW:0]        mid_w;
  logic [NW-1:0]      mid;
  logic [NW-1:0]      lc;
  logic [48:0]        pl;
  logic [47:0]        ph;
  logic [34:0]        rsh;
  logic               ge;
  logic [40:0]        qc;
  logic signed [41:0] sv;
  logic signed [42:0] sum;
  logic [31:0]        sat;

  assign deq_ready = (state == S_IDLE);
  assign mem_we    = (state == S_IDLE) && deq_valid && (deq_entry.kind == K_LOAD);
  assign wa        = AW'(deq_entry.idx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      times[wa]  <= deq_entry.ktime;
      values[wa] <= deq_entry.data;
    end
    rt <= times[ra];
    rv <= values[ra];
  end

  always_comb begin
    ma    = a[32] ? 33'(-a) : 33'(a);
    mb    = b[32] ? 32'(-b) : 32'(b);
    md    = d[32] ? 33'(-d) : 33'(d);
    neg   = a[32] ^ b[32] ^ d[32];
    nm1   = n - NW'(1);
    mid_w = ((NW+1)'(lo) + (NW+1)'(hi)) >> 1;
    mid   = mid_w[NW-1:0];
    if (lo < NW'(1)) begin
      lc = NW'(1);
    end else if (lo > nm1) begin
      lc = nm1;
    end else begin
      lc = lo;
    end
    pl  = ma[16:0] * mb;
    ph  = ma[32:17] * mb;
    rsh = {rem[33:0], prod[63]};
    ge  = (rsh >= {2'b00, md});
    qc  = (prod > QMAG_LIMIT) ? QMAG_LIMIT[40:0] : prod[40:0];
    sv  = neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    sum = 43'($signed(base)) + 43'(sv);
    if (sum > 43'sd2147483647) begin
      sat = 32'h7FFFFFFF;
    end else if (sum < -43'sd2147483648) begin
      sat = 32'h80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      after     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (deq_valid) begin
            case (deq_entry.kind)
              K_LOAD: begin
                state <= S_IDLE;
              end
              K_EMPTY: begin
                res_value  <= 32'd0;
                res_status <= 1'b1;
                state      <= S_EMIT;
              end
              K_UNIT: begin
                res_value  <= ONE_Q24;
                res_status <= 1'b0;
                state      <= S_EMIT;
              end
              default: begin
                tq    <= deq_entry.data;
                i     <= '0;
                ra    <= '0;
                after <= S_SCAN;
                state <= S_WAIT;
              end
            endcase
          end
        end
        S_WAIT: begin
          state <= after;
        end
        S_SCAN: begin
          if ({1'b0, rt} == tq) begin
            res_value  <= rv;
            res_status <= 1'b0;
            state      <= S_EMIT;
          end else begin
            if (i == '0) begin
              tf <= rt;
              yf <= rv;
            end
            if (NW'(i) == nm1) begin
              tl    <= rt;
              yl    <= rv;
              state <= S_CLS;
            end else begin
              i     <= i + AW'(1);
              ra    <= i + AW'(1);
              after <= S_SCAN;
              state <= S_WAIT;
            end
          end
        end
        S_CLS: begin
          if (tq < {1'b0, tf}) begin
            a     <= 33'($signed(yf));
            b     <= $signed({1'b0, tq});
            d     <= $signed({2'b00, tf});
            base  <= 32'd0;
            state <= S_MUL0;
          end else if (tq >= {1'b0, tl}) begin
            res_value  <= yl;
            res_status <= 1'b0;
            state      <= S_EMIT;
          end else begin
            lo    <= '0;
            hi    <= n;
            state <= S_BS;
          end
        end
        S_BS: begin
          if (lo < hi) begin
            ra    <= mid[AW-1:0];
            after <= S_BSC;
            state <= S_WAIT;
          end else begin
            lo    <= lc;
            ra    <= AW'(lc - NW'(1));
            after <= S_G0;
            state <= S_WAIT;
          end
        end
        S_BSC: begin
          if ({1'b0, rt} < tq) begin
            lo <= mid + NW'(1);
          end else begin
            hi <= mid;
          end
          state <= S_BS;
        end
        S_G0: begin
          tf    <= rt;
          base  <= rv;
          b     <= $signed({1'b0, tq}) - $signed({2'b00, rt});
          ra    <= AW'(lo);
          after <= S_G1;
          state <= S_WAIT;
        end
        S_G1: begin
          a     <= 33'($signed(rv)) - 33'($signed(base));
          d     <= $signed({2'b00, rt}) - $signed({2'b00, tf});
          state <= S_MUL0;
        end
        S_MUL0: begin
          if (md == 33'd0) begin
            prod  <= 64'd0;
            state <= S_FIN;
          end else begin
            prod  <= 64'(pl);
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod  <= prod + (64'(ph) << 17);
          rem   <= 35'd0;
          cnt   <= 6'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= ge ? (rsh - {2'b00, md}) : rsh;
          prod <= {prod[62:0], ge};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          res_value  <= sat;
          res_status <= 1'b0;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            curve_value <= res_value;
            status      <= res_status;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/piecewise_linear_table_interp.sv
// Piecewise linear curve over a table of up to MAX_KNOTS knots, signed Q8.24.
// Input channel (in_valid/in_ready): action 0 loads knot_time/knot_value into
// slot knot_index and gives no result; action 1 evaluates the curve at
// query_time and gives one beat on the output channel (out_valid/out_ready).
// cfg_wen/cfg_wdata set knot_count; min(knot_count, MAX_KNOTS) knots are used.
// A two-beat queue sits between the intake and the evaluator, so intake goes
// on while the evaluator works or the output waits.
// A load is written to its slot when the evaluator takes it from the queue.
// An empty table or a time at or below zero gives its beat with no search.
// Other queries run in the evaluator from a single read port: a match scan
// over the n knots that stops at an exact match, or else a time at or past
// the last knot gives that knot's value; other times take a binary search
// and knot fetch (if between knots), a two-part multiply and a division of
// one quotient bit per cycle. One query is evaluated at a time.
// Reset empties the queue and output, and clears knot_count; knot slots
// keep their contents until written. A stalled output holds its beat and
// the evaluator waits; the input stalls once the queue fills.
`default_nettype none

module piecewise_linear_table_interp import plti_pkg::*; #(
  parameter int MAX_KNOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [5:0]  knot_index,
  input  wire logic [30:0] knot_time,
  input  wire logic [31:0] knot_value,
  input  wire logic [31:0] query_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      curve_value,
  output logic             status
);

  localparam int NW = $clog2(MAX_KNOTS + 1);

  logic [6:0]    knot_count;
  logic [NW-1:0] n;
  logic          deq_valid;
  logic          deq_ready;
  entry_t        deq_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count <= 7'd0;
    end else if (cfg_wen) begin
      knot_count <= cfg_wdata;
    end
  end

  assign n = (32'(knot_count) > MAX_KNOTS) ? NW'(MAX_KNOTS) : NW'(knot_count);

  plti_front #(.MAX_KNOTS(MAX_KNOTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .knot_index (knot_index),
    .knot_time  (knot_time),
    .knot_value (knot_value),
    .query_time (query_time),
    .n_zero     (n == '0),
    .deq_valid  (deq_valid),
    .deq_ready  (deq_ready),
    .deq_entry  (deq_entry)
  );

  plti_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .n           (n),
    .deq_valid   (deq_valid),
    .deq_ready   (deq_ready),
    .deq_entry   (deq_entry),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .curve_value (curve_value),
    .status      (status)
  );

endmodule

`default_nettype wire

>>> verif/piecewise_linear_table_interp_tb.sv
`default_nettype none

module piecewise_linear_table_interp_tb import plti_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = 64;
  localparam int IDLE_PCT = 21;
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_QUERY = 1'b1;
  localparam logic ST_OK = 1'b0;
  localparam logic ST_EMPTY = 1'b1;
  localparam longint QUOT_CAP = 64'd1 << 40;

  typedef struct {
    logic [31:0] value;
    logic        status;
  } curve_beat_t;

  class curve_scoreboard;
    bit [30:0]   ktimes[NUM_SLOTS];
    logic [31:0] kvalues[NUM_SLOTS];
    bit [6:0]    count;
    curve_beat_t pending_q[$];
    int          errors;

    function int knots_in_use();
      return (count > NUM_SLOTS) ? NUM_SLOTS : int'(count);
    endfunction

    function longint scaled_quotient(longint a, longint b, longint d);
      bit [63:0] ma, mb, md, q;
      bit        neg;
      if (d == 0) return 0;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      md = (d < 0) ? -d : d;
      neg = ((a < 0) != (b < 0)) != (d < 0);
      q = (ma * mb) / md;
      if (q > QUOT_CAP) q = QUOT_CAP;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function logic [31:0] curve_at(longint t, int n);
      int     lo, hi, mid;
      longint t0, t1, y0, y1;
      if (t <= 0) return ONE_Q24;
      for (int i = 0; i < n; i++)
        if (longint'(ktimes[i]) == t) return kvalues[i];
      if (t < longint'(ktimes[0]))
        return clamp32(scaled_quotient(longint'(signed'(kvalues[0])), t,
                                       longint'(ktimes[0])));
      if (t >= longint'(ktimes[n-1])) return kvalues[n-1];
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (longint'(ktimes[mid]) < t) lo = mid + 1;
        else hi = mid;
      end
      if (lo < 1) lo = 1;
      if (lo > n - 1) lo = n - 1;
      t0 = longint'(ktimes[lo-1]);
      t1 = longint'(ktimes[lo]);
      y0 = longint'(signed'(kvalues[lo-1]));
      y1 = longint'(signed'(kvalues[lo]));
      return clamp32(y0 + scaled_quotient(y1 - y0, t - t0, t1 - t0));
    endfunction

    function void note_input(logic act, logic [5:0] idx, logic [30:0] kt,
                             logic [31:0] kv, logic [31:0] qt);
      curve_beat_t b;
      int          n;
      if (act == ACT_LOAD) begin
        ktimes[idx] = kt;
        kvalues[idx] = kv;
        return;
      end
      n = knots_in_use();
      if (n == 0) begin
        b.value = '0;
        b.status = ST_EMPTY;
      end else begin
        b.value = curve_at(longint'(signed'(qt)), n);
        b.status = ST_OK;
      end
      pending_q.push_back(b);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] value, logic status);
      curve_beat_t b;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected beat value=%h status=%0d", value, status));
        return;
      end
      b = pending_q.pop_front();
      if (value !== b.value)
        report($sformatf("curve_value got %h exp %h", value, b.value));
      if (status !== b.status)
        report($sformatf("status got %0d exp %0d", status, b.status));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [5:0]  knot_index = '0;
  logic [30:0] knot_time = '0;
  logic [31:0] knot_value = '0;
  logic [31:0] query_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] curve_value;
  logic        status;

  curve_scoreboard sb = new();
  bit              no_idle = 1'b0;
  int              items_sent = 0;

  piecewise_linear_table_interp dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .knot_index(knot_index), .knot_time(knot_time), .knot_value(knot_value),
    .query_time(query_time), .out_valid(out_valid), .out_ready(out_ready),
    .curve_value(curve_value), .status(status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(curve_value, status);
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  task send_beat(logic act, logic [5:0] idx, logic [30:0] kt, logic [31:0] kv,
                 logic [31:0] qt);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    knot_index <= idx;
    knot_time <= kt;
    knot_value <= kv;
    query_time <= qt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(act, idx, kt, kv, qt);
    items_sent++;
  endtask

  task load_knot(logic [5:0] idx, logic [30:0] kt, logic [31:0] kv);
    send_beat(ACT_LOAD, idx, kt, kv, $urandom);
  endtask

  task query(logic [31:0] qt);
    send_beat(ACT_QUERY, 6'($urandom), 31'($urandom), $urandom, qt);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task set_knot_count(logic [6:0] c);
    wait_drained();
    cfg_wen <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.count = c;
  endtask

  task fill_table(int n, bit ordered);
    bit [31:0] cur, span;
    cur = $urandom_range(1, 32'h0200_0000);
    for (int i = 0; i < n; i++) begin
      if (!ordered) begin
        cur = ($urandom_range(3) == 0 && i > 0) ? {1'b0, sb.ktimes[i-1]} : $urandom;
      end else if (i > 0) begin
        span = (32'h7fffffff - cur) / (n - i + 1);
        if (span < 1) span = 1;
        cur = cur + (($urandom_range(4) == 0) ? 1 : $urandom_range(1, span));
        if (cur > 32'h7fffffff) cur = 32'h7fffffff;
      end
      load_knot(i[5:0], cur[30:0],
                ($urandom_range(2) == 0) ? $urandom_range(0, 32'h0400_0000) : $urandom);
    end
  endtask

  function logic [31:0] pick_query_time(int n);
    int        k;
    bit [31:0] a, b;
    if (n == 0) return $urandom;
    k = $urandom_range(n - 1);
    a = {1'b0, sb.ktimes[0]};
    b = {1'b0, sb.ktimes[n-1]};
    case ($urandom_range(7))
      0: return $urandom;
      1: return {1'b0, sb.ktimes[k]};
      2: return {1'b0, sb.ktimes[k]} + 32'd1;
      3: return {1'b0, sb.ktimes[k]} - 32'd1;
      4: return (a > 1) ? $urandom_range(1, a - 1) : 1;
      5: return -$urandom_range(0, 32'h7fffffff);
      6: return (b < 32'h7fffffff) ? $urandom_range(b, 32'h7fffffff) : b;
      default: return (b > a) ? $urandom_range(a, b) : a;
    endcase
  endfunction

  initial begin
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int  n, c;
    bit  ordered;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    query(32'h0000_1000);
    set_knot_count(7'd1);
    load_knot(6'd0, 31'h7fffffff, 32'h80000000);
    query(32'd0);
    query(32'hffffffff);
    query(32'h80000000);
    query(32'h7fffffff);
    query(32'd1);
    query(32'h40000000);
    set_knot_count(7'd3);
    load_knot(6'd0, 31'd1 << 24, 32'h7fffffff);
    load_knot(6'd1, 31'd2 << 24, 32'h80000000);
    load_knot(6'd2, 31'd3 << 24, 32'd5);
    load_knot(6'd63, 31'd0, 32'hffffffff);
    query(32'h0180_0000);
    query(32'h0280_0000);
    query(32'd2 << 24);
    query(32'd4 << 24);
    query(32'h0080_0000);
    set_knot_count(7'd3);
    load_knot(6'd1, 31'd1 << 24, 32'd7);
    query(32'h0100_0000);
    query(32'h0180_0000);

    while (items_sent < 1550) begin
      case ($urandom_range(9))
        0: c = 0;
        1: c = 64;
        2: c = 127;
        3: c = $urandom_range(65, 127);
        4, 5: c = $urandom_range(1, 64);
        default: c = $urandom_range(1, 8);
      endcase
      no_idle = ($urandom_range(5) == 0);
      set_knot_count(c[6:0]);
      n = sb.knots_in_use();
      ordered = ($urandom_range(4) != 0);
      fill_table(n, ordered);
      repeat ($urandom_range(20, 40)) begin
        if ($urandom_range(9) < 8) begin
          query(pick_query_time(n));
        end else if (n < NUM_SLOTS) begin
          load_knot(6'($urandom_range(n, NUM_SLOTS - 1)), 31'($urandom), $urandom);
        end else begin
          load_knot(6'($urandom_range(NUM_SLOTS - 1)), 31'($urandom), $urandom);
        end
      end
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> piecewise_linear_table_interp.f
rtl/plti_pkg.sv
rtl/plti_front.sv
rtl/plti_back.sv
rtl/piecewise_linear_table_interp.sv
verif/piecewise_linear_table_interp_tb.sv
